/* rtl/stps_pkg.sv */
// stps_pkg: shared widths, register index codes and types for the pattern search block
// no dependencies; imported by stps_cfg_regs, shift_table_pattern_search and the testbench files
`default_nettype none

package stps_pkg;

    localparam int TEXT_W      = 8;
    localparam int MATCH_POS_W = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int LEN_REG_W   = 5;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t REG_PAT_LOW  = 2'd0;
    localparam cfg_index_t REG_PAT_HIGH = 2'd1;
    localparam cfg_index_t REG_PAT_LEN  = 2'd2;

endpackage

`default_nettype wire

/* rtl/stps_shift_ram.sv */
// stps_shift_ram: shift table storage, one write port and one registered read port
// no dependencies; instantiated by shift_table_pattern_search
`default_nettype none

module stps_shift_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/stps_cfg_regs.sv */
// stps_cfg_regs: pattern and length registers, pattern byte select, effective length
// depends on stps_pkg
`default_nettype none

module stps_cfg_regs #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  stps_pkg::cfg_index_t                cfg_index,
    input  logic [stps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [$clog2(PATTERN_MAX)-1:0]      pat_addr,
    output logic [stps_pkg::TEXT_W-1:0]         pat_byte,
    output logic [$clog2(PATTERN_MAX+1)-1:0]    eff_len,
    output logic                                cfg_hit
);

    import stps_pkg::*;

    localparam int CW = $clog2(PATTERN_MAX + 1);

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_REG_W-1:0]  len_reg;
    logic [TEXT_W-1:0]     pat_arr [PATTERN_MAX];

    assign cfg_hit = cfg_we && (cfg_index == REG_PAT_LOW || cfg_index == REG_PAT_HIGH ||
                                cfg_index == REG_PAT_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= LEN_REG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                REG_PAT_HIGH: pat_high_reg <= cfg_wdata;
                REG_PAT_LEN:  len_reg      <= cfg_wdata[LEN_REG_W-1:0];
                default:      ;
            endcase
        end
    end

    // bytes 0..7 from the low word, 8..15 from the high word
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (i < 8)
            begin
                pat_arr[i] = pat_low_reg[(i & 7) * 8 +: 8];
            end
            else
            begin
                pat_arr[i] = pat_high_reg[(i & 7) * 8 +: 8];
            end
        end
    end

    assign pat_byte = pat_arr[pat_addr];

    // zero length acts as one, oversize clamps to the table depth
    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = CW'(1);
        end
        else if (len_reg > LEN_REG_W'(PATTERN_MAX))
        begin
            eff_len = CW'(PATTERN_MAX);
        end
        else
        begin
            eff_len = CW'(len_reg);
        end
    end

endmodule

`default_nettype wire

/* rtl/shift_table_pattern_search.sv */
// shift_table_pattern_search: first-match byte pattern search with a stored shift table
// a byte that needs no fallback and finds the result slot free finishes in its accept cycle,
// result shown the next cycle; each fallback step through the shift table adds a ram read and a compare
// throughput: 1 byte per cycle without fallback and with the result slot free; fallback steps hold input
// reset or any write to a pattern or length register rebuilds the table, with no input taken
// meanwhile; depends on stps_pkg, stps_cfg_regs, stps_shift_ram
`default_nettype none

module shift_table_pattern_search #(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [stps_pkg::TEXT_W-1:0]        s_axis_tdata,   // text_byte
    input  logic                               s_axis_tlast,   // last_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [stps_pkg::MATCH_POS_W-1:0]   m_axis_tdata,   // match_position
    output logic [0:0]                         m_axis_tuser,   // found
    input  logic                               cfg_we,
    input  stps_pkg::cfg_index_t               cfg_index,
    input  logic [stps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import stps_pkg::*;

    localparam int AW = $clog2(PATTERN_MAX);
    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int SW = (POSITION_BITS + 1 > MATCH_POS_W) ? POSITION_BITS + 1 : MATCH_POS_W;

    typedef enum logic [2:0] {
        ST_BUILD0,
        ST_BUILD1,
        ST_BLOAD,
        ST_BCMP,
        ST_BWAIT,
        ST_IDLE,
        ST_CMP,
        ST_WAIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            k_reg, k_next;
    logic [AW-1:0]            q_reg, q_next;
    logic [TEXT_W-1:0]        c_reg, c_next;
    logic                     last_reg, last_next;
    logic [CW-1:0]            matched_reg, matched_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     reported_reg, reported_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg, found_next;
    logic [MATCH_POS_W-1:0]   mpos_reg, mpos_next;

    logic [AW-1:0]            pat_addr;
    logic [TEXT_W-1:0]        pat_byte;
    logic [CW-1:0]            eff_len;
    logic                     cfg_hit;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [AW-1:0]            mem_wdata;
    logic [AW-1:0]            rd_data;

    logic                     in_idle;
    logic [CW-1:0]            eng_k;
    logic [TEXT_W-1:0]        eng_c;
    logic                     pat_eq;
    logic                     mism;
    logic [CW-1:0]            k_inc;
    logic [CW-1:0]            q_inc;
    logic [CW-1:0]            bshift;
    logic                     cur_last;
    logic                     hit;
    logic                     need_out;
    logic                     slot_free;
    logic                     can_finish;
    logic                     finish;
    logic [SW-1:0]            start_sum;

    stps_cfg_regs #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pat_addr  (pat_addr),
        .pat_byte  (pat_byte),
        .eff_len   (eff_len),
        .cfg_hit   (cfg_hit)
    );

    stps_shift_ram #(
        .DEPTH (PATTERN_MAX),
        .AW    (AW),
        .DW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (eng_k[AW-1:0]),
        .rdata (rd_data)
    );

    // shared compare step: build compares the pattern with itself, search with the text
    assign in_idle  = (state_reg == ST_IDLE);
    assign eng_k    = in_idle ? ((matched_reg >= eff_len) ? '0 : matched_reg) : k_reg;
    assign eng_c    = in_idle ? s_axis_tdata : c_reg;
    assign pat_addr = (state_reg == ST_BLOAD) ? q_reg : eng_k[AW-1:0];
    assign pat_eq   = (pat_byte == eng_c);
    assign mism     = (eng_k != '0) && !pat_eq;
    assign k_inc    = eng_k + CW'(pat_eq);
    assign q_inc    = CW'(q_reg) + CW'(1);
    assign bshift   = q_inc - k_inc;

    assign cur_last   = in_idle ? s_axis_tlast : last_reg;
    assign hit        = !reported_reg && !mism && (k_inc >= eff_len);
    assign need_out   = !reported_reg && (hit || cur_last);
    assign slot_free  = !out_valid_reg || m_axis_tready;
    assign can_finish = (reported_reg || !mism) && (!need_out || slot_free);
    assign start_sum  = SW'(pos_reg) + SW'(1) - SW'(eff_len);

    assign s_axis_tready = in_idle;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = mpos_reg;
    assign m_axis_tuser  = found_reg;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        q_next         = q_reg;
        c_next         = c_reg;
        last_next      = last_reg;
        matched_next   = matched_reg;
        pos_next       = pos_reg;
        reported_next  = reported_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        found_next     = found_reg;
        mpos_next      = mpos_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        finish         = 1'b0;

        unique case (state_reg)
            ST_BUILD0:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = AW'(1);
                state_next = ST_BUILD1;
            end
            ST_BUILD1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(1);
                mem_wdata  = AW'(1);
                q_next     = AW'(1);
                k_next     = '0;
                state_next = (PATTERN_MAX == 2) ? ST_IDLE : ST_BLOAD;
            end
            ST_BLOAD:
            begin
                c_next     = pat_byte;
                state_next = ST_BCMP;
            end
            ST_BCMP:
            begin
                if (mism)
                begin
                    state_next = ST_BWAIT;
                end
                else
                begin
                    // entry q+1 gets its shift from the border length just found
                    mem_we     = 1'b1;
                    mem_waddr  = q_inc[AW-1:0];
                    mem_wdata  = bshift[AW-1:0];
                    k_next     = k_inc;
                    q_next     = q_inc[AW-1:0];
                    state_next = (q_inc == CW'(PATTERN_MAX - 1)) ? ST_IDLE : ST_BLOAD;
                end
            end
            ST_BWAIT:
            begin
                k_next     = k_reg - CW'(rd_data);
                state_next = ST_BCMP;
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (can_finish)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        c_next     = s_axis_tdata;
                        last_next  = s_axis_tlast;
                        k_next     = eng_k;
                        state_next = (mism && !reported_reg) ? ST_WAIT : ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                if (can_finish)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (mism && !reported_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                k_next     = k_reg - CW'(rd_data);
                state_next = ST_CMP;
            end
            default:
            begin
                state_next = ST_BUILD0;
            end
        endcase

        if (finish)
        begin
            if (!reported_reg)
            begin
                matched_next = hit ? '0 : k_inc;
            end
            if (need_out)
            begin
                out_valid_next = 1'b1;
                found_next     = hit;
                mpos_next      = hit ? start_sum[MATCH_POS_W-1:0] : '0;
            end
            if (cur_last)
            begin
                matched_next  = '0;
                pos_next      = '0;
                reported_next = 1'b0;
            end
            else
            begin
                reported_next = reported_reg || hit;
                if (!(&pos_reg))
                begin
                    pos_next = pos_reg + POSITION_BITS'(1);
                end
            end
        end

        // any accepted register write rebuilds the table and restarts the search
        if (cfg_hit)
        begin
            state_next    = ST_BUILD0;
            matched_next  = '0;
            pos_next      = '0;
            reported_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BUILD0;
            k_reg         <= '0;
            q_reg         <= '0;
            c_reg         <= '0;
            last_reg      <= 1'b0;
            matched_reg   <= '0;
            pos_reg       <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            mpos_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            q_reg         <= q_next;
            c_reg         <= c_next;
            last_reg      <= last_next;
            matched_reg   <= matched_next;
            pos_reg       <= pos_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            mpos_reg      <= mpos_next;
        end
    end

    // a write to a pattern or length register always stops input for the rebuild
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !s_axis_tready)
        else $error("input taken right after a config write");

    // a fallback step reads a nonzero shift no larger than the matched count
    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT || state_reg == ST_BWAIT) |->
            (rd_data != '0 && CW'(rd_data) <= k_reg))
        else $error("shift table entry out of range");

    // between bytes the matched count stays below the pattern length
    a_matched_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        in_idle |-> (matched_reg < eff_len))
        else $error("matched count reached pattern length while idle");

    // a not-found beat carries position zero
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("not-found beat with nonzero position");

endmodule

`default_nettype wire

/* tb/sv/stps_search_checker.sv */
// stps_search_checker: watches the text, result and register ports of the pattern search
// block, predicts each result and compares it; depends on stps_pkg
`timescale 1ns / 100ps

module stps_search_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [stps_pkg::TEXT_W-1:0]        s_axis_tdata,   // text_byte
    input  logic                               s_axis_tlast,   // last_byte
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [stps_pkg::MATCH_POS_W-1:0]   m_axis_tdata,   // match_position
    input  logic [0:0]                         m_axis_tuser,   // found
    input  logic                               cfg_we,
    input  stps_pkg::cfg_index_t               cfg_index,
    input  logic [stps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output int                                 outstanding,
    output int                                 failures,
    output int                                 results_checked
);
    import stps_pkg::*;

    localparam int PAT_MAX = 16;
    localparam logic [MATCH_POS_W-1:0] POS_LIMIT = '1;

    typedef struct packed {
        logic                   found;
        logic [MATCH_POS_W-1:0] position;
    } search_result_t;

    search_result_t search_results_due [$];

    logic [CFG_DATA_W-1:0]  pat_low_word;
    logic [CFG_DATA_W-1:0]  pat_high_word;
    logic [LEN_REG_W-1:0]   len_reg;
    logic [TEXT_W-1:0]      pat_byte [PAT_MAX];
    logic [4:0]             fallback_shift [PAT_MAX];
    int                     matched_bytes;
    logic [MATCH_POS_W-1:0] next_index;
    logic                   reported;
    int                     fail_count;
    int                     checked_count;

    function automatic int active_length(input logic [LEN_REG_W-1:0] r);
        int n;
        n = r;
        if (n == 0)
            n = 1;
        if (n > PAT_MAX)
            n = PAT_MAX;
        return n;
    endfunction

    // entry m: smallest shift whose overlap with the matched prefix still agrees
    task automatic rebuild_shift_table;
        int  i;
        int  m;
        int  s;
        int  p;
        bit  fits;
        bit  found_shift;
        for (i = 0; i < PAT_MAX; i++)
            pat_byte[i] = (i < 8) ? pat_low_word[i*8 +: 8] : pat_high_word[(i-8)*8 +: 8];
        fallback_shift[0] = 5'd1;
        fallback_shift[1] = 5'd1;
        for (m = 2; m < PAT_MAX; m++)
        begin
            fallback_shift[m] = 5'(m);
            found_shift = 1'b0;
            for (s = 1; s < m && !found_shift; s++)
            begin
                fits = 1'b1;
                for (p = s; p < m; p++)
                    if (pat_byte[p] != pat_byte[p - s])
                        fits = 1'b0;
                if (fits)
                begin
                    fallback_shift[m] = 5'(s);
                    found_shift = 1'b1;
                end
            end
        end
        matched_bytes = 0;
        next_index = '0;
        reported = 1'b0;
    endtask

    task automatic advance_search(input logic [TEXT_W-1:0] c, input logic last_flag);
        int                     len;
        int                     m;
        int                     guard;
        logic [MATCH_POS_W-1:0] len16;
        search_result_t         r;
        len = active_length(len_reg);
        len16 = len[MATCH_POS_W-1:0];
        if (!reported)
        begin
            m = matched_bytes;
            if (m >= len)
                m = 0;
            guard = 0;
            while (guard < PAT_MAX && m > 0 && pat_byte[m] != c)
            begin
                m = m - fallback_shift[m];
                guard++;
            end
            if (pat_byte[m] == c)
                m++;
            if (m >= len)
            begin
                reported = 1'b1;
                r.found = 1'b1;
                r.position = next_index + 16'd1 - len16;
                search_results_due.push_back(r);
                m = 0;
            end
            matched_bytes = m;
        end
        if (last_flag)
        begin
            if (!reported)
            begin
                r.found = 1'b0;
                r.position = '0;
                search_results_due.push_back(r);
            end
            matched_bytes = 0;
            next_index = '0;
            reported = 1'b0;
        end
        else if (next_index != POS_LIMIT)
            next_index = next_index + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_word = '0;
            pat_high_word = '0;
            len_reg = 5'd1;
            rebuild_shift_table();
            search_results_due.delete();
            fail_count = 0;
            checked_count = 0;
        end
        else
        begin
            // results are registered, so this beat never belongs to a byte taken this edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (search_results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: found=%0d position=%0d",
                                 m_axis_tuser[0], m_axis_tdata);
                end
                else
                begin
                    search_result_t want;
                    want = search_results_due.pop_front();
                    checked_count++;
                    if (want.found !== m_axis_tuser[0] || want.position !== m_axis_tdata)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result %0d wrong: expected found=%0d position=%0d,",
                                      " got found=%0d position=%0d"},
                                     checked_count, want.found, want.position,
                                     m_axis_tuser[0], m_axis_tdata);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PAT_LOW:
                    begin
                        pat_low_word = cfg_wdata;
                        rebuild_shift_table();
                    end
                    REG_PAT_HIGH:
                    begin
                        pat_high_word = cfg_wdata;
                        rebuild_shift_table();
                    end
                    REG_PAT_LEN:
                    begin
                        len_reg = cfg_wdata[LEN_REG_W-1:0];
                        rebuild_shift_table();
                    end
                    default:
                        ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_search(s_axis_tdata, s_axis_tlast);
        end
        outstanding <= search_results_due.size();
        failures <= fail_count;
        results_checked <= checked_count;
    end

endmodule

/* tb/sv/tb_shift_table_pattern_search.sv */
// tb_shift_table_pattern_search: drives texts and pattern registers into the search block
// and reports the verdict; depends on stps_pkg, stps_search_checker and the block's rtl
`timescale 1ns / 100ps

module tb_shift_table_pattern_search;
    import stps_pkg::*;

    localparam cfg_index_t REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES   = 80;
    localparam int PHASE_BYTES     = 550;
    localparam int TIMEOUT_NS      = 4_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TEXT_W-1:0]      s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [MATCH_POS_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   cfg_we = 1'b0;
    cfg_index_t             cfg_index = REG_PAT_LOW;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int outstanding;
    int failures;
    int results_checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int texts_sent = 0;
    int bytes_sent = 0;
    int reg_writes = 0;

    logic [TEXT_W-1:0] pat_src [16];
    int                pat_active = 1;
    logic [TEXT_W-1:0] text_buf [$];

    always #2 clk = ~clk;

    shift_table_pattern_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    stps_search_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .outstanding     (outstanding),
        .failures        (failures),
        .results_checked (results_checked)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic drive_text_beat(input logic [TEXT_W-1:0] b, input logic last_flag);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last_flag;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_span(input int lo, input int hi, input bit end_text);
        int i;
        for (i = lo; i < hi; i++)
            drive_text_beat(text_buf[i], end_text && (i == hi - 1));
        if (end_text)
            texts_sent++;
    endtask

    // stop sending and let every pending result and any trailing fallback finish
    task automatic wait_quiet;
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        reg_writes++;
    endtask

    task automatic program_pattern(input logic [CFG_DATA_W-1:0] len_word);
        logic [CFG_DATA_W-1:0] low_word;
        logic [CFG_DATA_W-1:0] high_word;
        int                    i;
        int                    n;
        for (i = 0; i < 8; i++)
        begin
            low_word[i*8 +: 8] = pat_src[i];
            high_word[i*8 +: 8] = pat_src[i+8];
        end
        write_reg(REG_PAT_LOW, low_word);
        write_reg(REG_PAT_HIGH, high_word);
        write_reg(REG_PAT_LEN, len_word);
        n = len_word[LEN_REG_W-1:0];
        if (n == 0)
            n = 1;
        if (n > 16)
            n = 16;
        pat_active = n;
    endtask

    // two-symbol patterns give long self-overlaps and deep fallback chains
    task automatic pick_pattern(output logic [CFG_DATA_W-1:0] len_word);
        int                i;
        int                mode;
        int                r;
        logic [TEXT_W-1:0] sym_a;
        logic [TEXT_W-1:0] sym_b;
        logic [4:0]        lenv;
        mode = $urandom_range(0, 2);
        sym_a = 8'($urandom_range(0, 255));
        sym_b = sym_a ^ (8'h01 << $urandom_range(0, 7));
        for (i = 0; i < 16; i++)
            if (mode == 0)
                pat_src[i] = 8'($urandom_range(0, 255));
            else
                pat_src[i] = $urandom_range(0, 1) ? sym_a : sym_b;
        r = $urandom_range(0, 99);
        if (r < 70)
            lenv = 5'($urandom_range(1, 6));
        else if (r < 88)
            lenv = 5'($urandom_range(7, 16));
        else if (r < 93)
            lenv = 5'd0;
        else
            lenv = 5'($urandom_range(17, 31));
        if ($urandom_range(0, 9) == 0)
            len_word = {$urandom, $urandom};
        else
            len_word = '0;
        len_word[4:0] = lenv;
    endtask

    task automatic build_text;
        int target;
        int r;
        int i;
        int at;
        text_buf.delete();
        target = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 30) : $urandom_range(31, 80);
        while (text_buf.size() < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                at = text_buf.size();
                for (i = 0; i < pat_active; i++)
                    text_buf.push_back(pat_src[i]);
                // broken copy: one flipped bit somewhere in it
                if ($urandom_range(0, 2) == 0)
                begin
                    i = at + $urandom_range(0, pat_active - 1);
                    text_buf[i] = text_buf[i] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
            else if (r < 88)
                text_buf.push_back(pat_src[$urandom_range(0, pat_active - 1)]);
            else
                text_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] len_word;
        int                    phase;
        int                    phase_start;
        int                    texts_left;
        int                    cut;
        int                    r;
        int                    i;

        for (i = 0; i < 16; i++)
            pat_src[i] = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern is one zero byte
        text_buf = '{8'h00};
        send_span(0, 1, 1);
        text_buf = '{8'hff, 8'h00, 8'h12};
        send_span(0, 3, 1);

        // fallback inside the pattern
        wait_quiet();
        pat_src[0] = 8'h61;
        pat_src[1] = 8'h61;
        pat_src[2] = 8'h62;
        program_pattern(64'd3);
        text_buf = '{8'h61, 8'h61, 8'h61, 8'h62};
        send_span(0, 4, 1);

        // register write mid-text restarts the search; length zero acts as one
        text_buf = '{8'h61, 8'h61};
        send_span(0, 2, 0);
        wait_quiet();
        pat_src[0] = 8'h62;
        program_pattern(64'd0);
        text_buf = '{8'h61, 8'h62};
        send_span(0, 2, 1);

        // all-ones registers: length clamps to sixteen
        wait_quiet();
        for (i = 0; i < 16; i++)
            pat_src[i] = 8'hff;
        program_pattern('1);
        text_buf.delete();
        for (i = 0; i < 16; i++)
            text_buf.push_back(8'hff);
        send_span(0, 16, 1);

        // write to the unused index leaves the pattern alone
        wait_quiet();
        write_reg(REG_UNUSED, '1);
        text_buf = '{8'h00};
        send_span(0, 1, 1);

        texts_left = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 8;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 8;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if (texts_left == 0)
                begin
                    wait_quiet();
                    if ($urandom_range(0, 7) == 0)
                        write_reg(REG_UNUSED, {$urandom, $urandom});
                    pick_pattern(len_word);
                    program_pattern(len_word);
                    texts_left = $urandom_range(2, 6);
                end
                build_text();
                cut = $urandom_range(1, text_buf.size());
                r = $urandom_range(0, 99);
                if (r < 5 && cut < text_buf.size())
                begin
                    send_span(0, cut, 0);
                    wait_quiet();
                    pick_pattern(len_word);
                    program_pattern(len_word);
                    texts_left = $urandom_range(2, 6);
                    send_span(cut, text_buf.size(), 1);
                end
                else if (r < 10 && cut < text_buf.size())
                begin
                    // hold the text until every result so far has drained
                    send_span(0, cut, 0);
                    wait_quiet();
                    send_span(cut, text_buf.size(), 1);
                end
                else
                    send_span(0, text_buf.size(), 1);
                texts_left--;
            end
        end

        wait_quiet();
        $display("searched %0d texts (%0d bytes) across %0d register writes, %0d results checked",
                 texts_sent, bytes_sent, reg_writes, results_checked);
        $display("included clamped lengths, mid-text restarts, fallbacks and output stalls");
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/stps_pkg.sv
rtl/stps_shift_ram.sv
rtl/stps_cfg_regs.sv
rtl/shift_table_pattern_search.sv
tb/sv/stps_search_checker.sv
tb/sv/tb_shift_table_pattern_search.sv
